[hw/rtl/bavg_pkg.sv]
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared types and constants of the box-average icon downscaler.
// ----------------------------------------------------------------------------
package bavg_pkg;

  localparam int NUM_CH = 4;
  localparam int CH_W   = 8;
  localparam int STEP_W = 3;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_EMIT = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] source_index;
    logic [31:0] pixel_value;
    logic [5:0]  output_row;
  } in_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic [5:0]  out_column;
    logic        last;
  } out_t;

endpackage

[hw/rtl/bavg_ram.sv]
// ----------------------------------------------------------------------------
// bavg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bavg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bavg_div.sv]
// ----------------------------------------------------------------------------
// bavg_div
// Four-lane restoring divider: divides each channel sum by the box pixel
// count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bavg_div
  import bavg_pkg::*;
#(
  parameter int SUM_W = 10,
  parameter int N_W   = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [NUM_CH-1:0][SUM_W-1:0]     sums,
  input  logic [N_W-1:0]                   count,
  output logic                             done,
  output logic [NUM_CH-1:0][CH_W-1:0]      quot
);

  localparam int CMP_W = N_W + CH_W;

  logic                          active;
  logic [STEP_W-1:0]             step;
  logic [CMP_W-1:0]              dvs;
  logic [NUM_CH-1:0][CMP_W-1:0]  rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(CH_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Average never exceeds 255, so the quotient settles in CH_W trial steps.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= CMP_W'(count) << (CH_W - 1);
      for (int c = 0; c < NUM_CH; c++) begin
        rem[c] <= CMP_W'(sums[c]);
      end
    end else if (active) begin
      dvs <= dvs >> 1;
      for (int c = 0; c < NUM_CH; c++) begin
        if (rem[c] >= dvs) begin
          rem[c]  <= rem[c] - dvs;
          quot[c] <= {quot[c][CH_W-2:0], 1'b1};
        end else begin
          quot[c] <= {quot[c][CH_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

[hw/rtl/box_average_icon_downscale.sv]
// ----------------------------------------------------------------------------
// box_average_icon_downscale
// Area-average downscaler of a premultiplied ARGB image to OUT_SIZE squared.
//
// Requests enter on start/request and are taken when start is high and busy
// is low. A load request writes one source pixel into the store and busy
// stays low. An emit request names an output row below OUT_SIZE; busy rises
// and OUT_SIZE results follow, one per column in order, each shown for one
// cycle with result_valid, last set on the final column. The receiver cannot
// stall, so results leave as they are computed.
// Per output pixel: two span steps through the reciprocal multiplier, one
// store read per box pixel (at most 4 with the default sizes), and eight
// steps of the shared four-lane divider; an emit request first runs the row
// span and row base steps. The user must write width and height over the
// APB port (offset 0 and 4) only while the block is idle; the block does
// not enforce it. Reset returns the control to idle and the dimensions to
// their default; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module box_average_icon_downscale
  import bavg_pkg::*;
#(
  parameter int OUT_SIZE   = 48,
  parameter int MAX_SOURCE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         request,
  output logic        result_valid,
  output out_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DIM_MAX   = (MAX_SOURCE > 127) ? 127 : MAX_SOURCE;
  localparam int DIM_W     = $clog2(DIM_MAX + 1);
  localparam int DIM_RESET = (MAX_SOURCE < 64) ? MAX_SOURCE : 64;
  localparam int DEPTH     = MAX_SOURCE * MAX_SOURCE;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W     = 2 * DIM_W;
  localparam int K_W       = 7;
  localparam int PROD_W    = K_W + DIM_W;
  localparam int SHIFT     = PROD_W + $clog2(OUT_SIZE);
  localparam int RECIP_W   = SHIFT + 1;
  localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + OUT_SIZE - 1) / OUT_SIZE;
  localparam int FULL_W    = PROD_W + RECIP_W;
  localparam int BOX_MAX   = (DIM_MAX + OUT_SIZE - 1) / OUT_SIZE;
  localparam int N_MAX     = BOX_MAX * BOX_MAX;
  localparam int N_W       = $clog2(N_MAX + 1);
  localparam int SUM_W     = $clog2(255 * N_MAX + 1);

  typedef enum logic [10:0] {
    IDLE    = 11'b000_0000_0001,
    ROW_MUL = 11'b000_0000_0010,
    ROW_DIV = 11'b000_0000_0100,
    BASE    = 11'b000_0000_1000,
    COL_MUL = 11'b000_0001_0000,
    COL_DIV = 11'b000_0010_0000,
    READ    = 11'b000_0100_0000,
    DRAIN   = 11'b000_1000_0000,
    LAUNCH  = 11'b001_0000_0000,
    DIVIDE  = 11'b010_0000_0000,
    EMIT    = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  logic [DIM_W-1:0] dim_next;

  logic [5:0]       row;
  logic [5:0]       col;
  logic [DIM_W-1:0] x0, x1, y0, y1, x, y;
  logic [IDX_W-1:0] row_base, row_cur;
  logic [PROD_W-1:0] prod_a, prod_b;

  logic [K_W-1:0]    span_k;
  logic [DIM_W-1:0]  span_size;
  logic [FULL_W-1:0] full_a, full_b;
  logic [DIM_W-1:0]  span_lo, span_hi;

  logic                          rd_valid;
  logic [31:0]                   rdata;
  logic [ADDR_W-1:0]             raddr;
  logic                          we;
  logic [N_W-1:0]                count;
  logic [NUM_CH-1:0][SUM_W-1:0]  sums;
  logic                          div_start, div_done;
  logic [NUM_CH-1:0][CH_W-1:0]   quot;

  logic cfg_write;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_HEIGHT) ? 32'(height) : 32'(width);

  always_comb begin
    if (pwdata[6:0] == 7'd0) begin
      dim_next = DIM_W'(1);
    end else if (32'(pwdata[6:0]) > MAX_SOURCE) begin
      dim_next = DIM_W'(MAX_SOURCE);
    end else begin
      dim_next = DIM_W'(pwdata[6:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= DIM_W'(DIM_RESET);
      height <= DIM_W'(DIM_RESET);
    end else if (cfg_write) begin
      if (paddr[2] == REG_HEIGHT) begin
        height <= dim_next;
      end else begin
        width <= dim_next;
      end
    end
  end

  // ---------------------------------------------------------------- store
  assign we = start && !busy && (request.action == ACTION_LOAD) &&
              (32'(request.source_index) < DEPTH);
  assign raddr = ADDR_W'(row_cur + IDX_W'(x));

  bavg_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (ADDR_W'(request.source_index)),
    .wdata (request.pixel_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------- span unit
  // Truncating divide by OUT_SIZE via an exact reciprocal multiply.
  always_comb begin
    if ((state == ROW_MUL) || (state == ROW_DIV)) begin
      span_k    = K_W'(row);
      span_size = height;
    end else begin
      span_k    = K_W'(col);
      span_size = width;
    end
    full_a  = FULL_W'(prod_a) * FULL_W'(RECIP);
    full_b  = FULL_W'(prod_b) * FULL_W'(RECIP);
    span_lo = DIM_W'(full_a >> SHIFT);
    span_hi = DIM_W'(full_b >> SHIFT);
    if (span_hi <= span_lo) begin
      span_hi = span_lo + DIM_W'(1);
    end
    if (span_hi > span_size) begin
      span_hi = span_size;
    end
    if (span_lo >= span_size) begin
      span_lo = span_size - DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ROW_MUL) || (state == COL_MUL)) begin
      prod_a <= PROD_W'(span_k) * PROD_W'(span_size);
      prod_b <= PROD_W'(span_k + K_W'(1)) * PROD_W'(span_size);
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign busy      = (state != IDLE);
  assign div_start = (state == LAUNCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      col      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == READ);
      case (state)
        IDLE: begin
          if (start && (request.action == ACTION_EMIT) &&
              (7'(request.output_row) < 7'(OUT_SIZE))) begin
            col   <= '0;
            state <= ROW_MUL;
          end
        end
        ROW_MUL: state <= ROW_DIV;
        ROW_DIV: state <= BASE;
        BASE:    state <= COL_MUL;
        COL_MUL: state <= COL_DIV;
        COL_DIV: state <= READ;
        READ: begin
          if ((x + DIM_W'(1) == x1) && (y + DIM_W'(1) == y1)) begin
            state <= DRAIN;
          end
        end
        DRAIN:  state <= LAUNCH;
        LAUNCH: state <= DIVIDE;
        DIVIDE: begin
          if (div_done) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (col == 6'(OUT_SIZE - 1)) begin
            col   <= '0;
            state <= IDLE;
          end else begin
            col   <= col + 6'd1;
            state <= COL_MUL;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Box walk and accumulation; data from a read lands in the next cycle.
  always_ff @(posedge clk) begin
    if ((state == IDLE) && start) begin
      row <= request.output_row;
    end
    if (state == ROW_DIV) begin
      y0 <= span_lo;
      y1 <= span_hi;
    end
    if (state == BASE) begin
      row_base <= IDX_W'(y0) * IDX_W'(width);
    end
    if (state == COL_DIV) begin
      x0      <= span_lo;
      x1      <= span_hi;
      x       <= span_lo;
      y       <= y0;
      row_cur <= row_base;
    end else if (state == READ) begin
      if (x + DIM_W'(1) == x1) begin
        x       <= x0;
        y       <= y + DIM_W'(1);
        row_cur <= row_cur + IDX_W'(width);
      end else begin
        x <= x + DIM_W'(1);
      end
    end
    if (state == COL_DIV) begin
      count <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] <= '0;
      end
    end else if (rd_valid) begin
      count <= count + N_W'(1);
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] <= sums[c] + SUM_W'(rdata[CH_W*(NUM_CH-1-c) +: CH_W]);
      end
    end
  end

  bavg_div #(
    .SUM_W (SUM_W),
    .N_W   (N_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sums  (sums),
    .count (count),
    .done  (div_done),
    .quot  (quot)
  );

  // ---------------------------------------------------------------- result
  assign result_valid = (state == EMIT);

  always_comb begin
    result.out_pixel = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      result.out_pixel[CH_W*(NUM_CH-1-c) +: CH_W] = quot[c];
    end
    result.out_column = col;
    result.last       = (col == 6'(OUT_SIZE - 1));
  end

endmodule
